### src/bat_pkg.sv
// Shared types, constants and the quarter-sine table for the byte angle core.
// No dependencies; every other file imports this package.
package bat_pkg;

  localparam int ANG_W  = 8;   // byte angle, 256 units per turn
  localparam int VEC_W  = 8;   // signed vector component
  localparam int MAG_W  = 7;   // magnitude of a saturated component
  localparam int SQ_W   = 15;  // x*x + y*y, at most 2*127*127
  localparam int ROOT_W = 8;   // root search value, 1..255
  localparam int RSQ_W  = 16;  // square of a root candidate
  localparam int NUM_W  = 13;  // 64*|v|, also the quotient width
  localparam int IDX_W  = 6;   // quarter-sine table index
  localparam int QS_W   = 7;   // table entry, 0..64

  localparam logic [IDX_W-1:0]  IDX_START  = 6'd32;
  localparam logic [4:0]        TSTEP_INIT = 5'd16;
  localparam logic [ROOT_W-1:0] ROOT_INIT  = 8'd128;
  localparam logic [RSQ_W-1:0]  RSQ_INIT   = 16'd16384;
  localparam logic [6:0]        RSTEP_INIT = 7'd64;
  localparam logic [ANG_W-1:0]  ANG_HALF   = 8'd128;
  localparam logic [IDX_W:0]    ANG_QUART  = 7'd64;

  // Quarter sine, 64 = unit.
  localparam logic [QS_W-1:0] QSINE [64] = '{
    7'd0,  7'd2,  7'd3,  7'd5,  7'd6,  7'd8,  7'd9,  7'd11,
    7'd12, 7'd14, 7'd16, 7'd17, 7'd19, 7'd20, 7'd22, 7'd23,
    7'd24, 7'd26, 7'd27, 7'd29, 7'd30, 7'd32, 7'd33, 7'd34,
    7'd36, 7'd37, 7'd38, 7'd39, 7'd41, 7'd42, 7'd43, 7'd44,
    7'd45, 7'd46, 7'd47, 7'd48, 7'd49, 7'd50, 7'd51, 7'd52,
    7'd53, 7'd54, 7'd55, 7'd56, 7'd56, 7'd57, 7'd58, 7'd59,
    7'd59, 7'd60, 7'd60, 7'd61, 7'd61, 7'd62, 7'd62, 7'd62,
    7'd63, 7'd63, 7'd63, 7'd64, 7'd64, 7'd64, 7'd64, 7'd64
  };

  function automatic logic [QS_W-1:0] qsine(input logic [IDX_W-1:0] i);
    return QSINE[i];
  endfunction

  // Controller to datapath commands.
  typedef struct packed {
    logic load;      // capture request vector
    logic sq_a;      // sq = |x|^2
    logic sq_b;      // sq += |y|^2
    logic rt_prop;   // propose next root candidate and its square
    logic rt_upd;    // keep candidate if closer, halve step
    logic div_init;  // load dividend, reset table search
    logic div_step;  // one restoring division bit
    logic ts_step;   // one table search step
    logic save;      // store search result as sine or cosine angle
    logic sel;       // 0: sine pass (y), 1: cosine pass (x)
    logic finish;    // fold into quadrant, register angle
  } bat_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic zero;      // request vector is (0,0)
  } bat_stat_t;

endpackage

### src/byte_angle_arctangent_core.sv
// Top level of the byte angle core: angle of a signed vector as one byte.
// Instantiates bat_ctrl and bat_dp; depends on bat_pkg.
//
//   channel   ports                   handshake
//   request   vec_x, vec_y            taken when start is high and busy is low
//   result    angle                   valid for the one cycle done is high
//
// A request runs through the square states, seven root steps of propose and
// update, two passes of a divider setup, a 13-bit restoring divide and a
// 5-step table search, and a fold state that registers the angle.
// The zero vector goes from the squares straight to the fold.
// busy is low again in the cycle done is high, ready for the next request.
// Synchronous reset returns the sequencer to idle and clears done.
// Results cannot be held off; the receiver must take angle while done is high.
module byte_angle_arctangent_core import bat_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic signed [VEC_W-1:0] vec_x,
  input  logic signed [VEC_W-1:0] vec_y,
  output logic                    busy,
  output logic                    done,
  output logic [ANG_W-1:0]        angle
);

  bat_cmd_t  cmd;
  bat_stat_t stat;

  bat_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  bat_dp u_dp (
    .clk   (clk),
    .rst   (rst),
    .cmd   (cmd),
    .vec_x (vec_x),
    .vec_y (vec_y),
    .stat  (stat),
    .done  (done),
    .angle (angle)
  );

endmodule

### src/bat_ctrl.sv
// Sequencer for the byte angle core: square, root search, two divide and
// table search passes, quadrant fold. Depends on bat_pkg.
module bat_ctrl import bat_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  bat_stat_t stat,
  output bat_cmd_t  cmd,
  output logic      busy
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SQA  = 4'd1;
  localparam logic [3:0] S_SQB  = 4'd2;
  localparam logic [3:0] S_RTP  = 4'd3;
  localparam logic [3:0] S_RTU  = 4'd4;
  localparam logic [3:0] S_DVI  = 4'd5;
  localparam logic [3:0] S_DIV  = 4'd6;
  localparam logic [3:0] S_TS   = 4'd7;
  localparam logic [3:0] S_FIN  = 4'd8;

  localparam logic [3:0] RT_LAST  = 4'd6;   // 7 root steps
  localparam logic [3:0] DIV_LAST = 4'd12;  // 13 quotient bits
  localparam logic [3:0] TS_LAST  = 4'd4;   // 5 search steps

  logic [3:0] state, state_next;
  logic [3:0] cnt, cnt_next;
  logic       pass, pass_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      pass  <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      pass  <= pass_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    pass_next  = pass;
    cmd        = '0;
    cmd.sel    = pass;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          pass_next  = 1'b0;
          state_next = S_SQA;
        end
      end
      S_SQA: begin
        cmd.sq_a   = 1'b1;
        state_next = S_SQB;
      end
      S_SQB: begin
        cmd.sq_b   = 1'b1;
        cnt_next   = RT_LAST;
        state_next = stat.zero ? S_FIN : S_RTP;
      end
      S_RTP: begin
        cmd.rt_prop = 1'b1;
        state_next  = S_RTU;
      end
      S_RTU: begin
        cmd.rt_upd = 1'b1;
        if (cnt == '0) begin
          state_next = S_DVI;
        end else begin
          cnt_next   = cnt - 4'd1;
          state_next = S_RTP;
        end
      end
      S_DVI: begin
        cmd.div_init = 1'b1;
        cnt_next     = DIV_LAST;
        state_next   = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt == '0) begin
          cnt_next   = TS_LAST;
          state_next = S_TS;
        end else begin
          cnt_next = cnt - 4'd1;
        end
      end
      S_TS: begin
        cmd.ts_step = 1'b1;
        if (cnt == '0) begin
          cmd.save = 1'b1;
          if (pass) begin
            state_next = S_FIN;
          end else begin
            pass_next  = 1'b1;
            state_next = S_DVI;
          end
        end else begin
          cnt_next = cnt - 4'd1;
        end
      end
      S_FIN: begin
        cmd.finish = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy = (state != S_IDLE);

endmodule

### src/bat_dp.sv
// Datapath of the byte angle core: squares, root search, restoring divider,
// quarter-sine table search and quadrant fold. Depends on bat_pkg.
module bat_dp import bat_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  bat_cmd_t                cmd,
  input  logic signed [VEC_W-1:0] vec_x,
  input  logic signed [VEC_W-1:0] vec_y,
  output bat_stat_t               stat,
  output logic                    done,
  output logic [ANG_W-1:0]        angle
);

  // request vector, saturated to +-127
  logic             xneg, xpos, yneg;
  logic [MAG_W-1:0] ax, ay;
  logic [SQ_W-1:0]  sq;

  // root search
  logic [ROOT_W-1:0] r, cand;
  logic [RSQ_W-1:0]  rsq, candsq;
  logic [6:0]        rstep;

  // divider; numq holds remaining dividend bits, then the quotient
  logic [ROOT_W-1:0] rem;
  logic [NUM_W-1:0]  numq;

  // table search
  logic [IDX_W-1:0] idx;
  logic [4:0]       tstep;
  logic [IDX_W-1:0] s_ang, c_ang;

  function automatic logic [MAG_W-1:0] mag_sat(input logic signed [VEC_W-1:0] v);
    logic [VEC_W-1:0] n;
    n = -v;
    if (v[VEC_W-1]) begin
      // -128 saturates to -127
      return (v == -8'sd128) ? 7'd127 : n[MAG_W-1:0];
    end
    return v[MAG_W-1:0];
  endfunction

  function automatic logic [NUM_W-1:0] tdiff(input logic [QS_W-1:0] q,
                                             input logic [NUM_W-1:0] t);
    logic signed [NUM_W:0] d;
    d = $signed({{(NUM_W-QS_W+1){1'b0}}, q}) - $signed({1'b0, t});
    return d[NUM_W] ? NUM_W'(-d) : d[NUM_W-1:0];
  endfunction

  function automatic logic [RSQ_W-1:0] sqerr(input logic [RSQ_W-1:0] a,
                                             input logic [SQ_W-1:0] s);
    logic signed [RSQ_W:0] d;
    d = $signed({1'b0, a}) - $signed({2'b0, s});
    return d[RSQ_W] ? RSQ_W'(-d) : d[RSQ_W-1:0];
  endfunction

  // full-width squares
  logic [SQ_W-1:0]  ax_w, ay_w;
  logic [RSQ_W-1:0] cand_w;
  assign ax_w = {{(SQ_W-MAG_W){1'b0}}, ax};
  assign ay_w = {{(SQ_W-MAG_W){1'b0}}, ay};

  // root candidate
  logic [ROOT_W-1:0] cand_c;
  assign cand_c = (rsq > {1'b0, sq}) ? r - {1'b0, rstep} : r + {1'b0, rstep};
  assign cand_w = {{(RSQ_W-ROOT_W){1'b0}}, cand_c};

  // divider bit
  logic [ROOT_W:0]   shifted;
  logic [ROOT_W+1:0] trial;
  assign shifted = {rem, numq[NUM_W-1]};
  assign trial   = {1'b0, shifted} - {2'b0, r};

  // table search step
  logic [QS_W-1:0]  q_here, q_alt;
  logic [IDX_W-1:0] alt, idx_next;
  logic             over;
  assign q_here   = qsine(idx);
  assign over     = {{(NUM_W-QS_W){1'b0}}, q_here} > numq;
  assign alt      = over ? idx - {1'b0, tstep} : idx + {1'b0, tstep};
  assign q_alt    = qsine(alt);
  assign idx_next = (tdiff(q_here, numq) > tdiff(q_alt, numq)) ? alt : idx;

  // reconcile and fold
  logic [IDX_W-1:0] a6;
  logic [ANG_W-1:0] a8, folded;
  assign a6 = (c_ang != s_ang && qsine(c_ang) == qsine(s_ang)) ? c_ang : s_ang;
  assign a8 = {2'b0, a6};

  always_comb begin
    folded = a8;
    if (!yneg) begin
      if (xneg) folded = ANG_HALF - a8;
    end else begin
      if (!xpos) folded = a8 + ANG_HALF;
      else       folded = 8'd0 - a8;   // 256 - a, modulo 256
    end
  end

  assign stat.zero = (ax == '0) && (ay == '0);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      xneg  <= vec_x[VEC_W-1];
      xpos  <= !vec_x[VEC_W-1] && (vec_x != '0);
      yneg  <= vec_y[VEC_W-1];
      ax    <= mag_sat(vec_x);
      ay    <= mag_sat(vec_y);
      r     <= ROOT_INIT;
      rsq   <= RSQ_INIT;
      rstep <= RSTEP_INIT;
    end
    if (cmd.sq_a) sq <= ax_w * ax_w;
    if (cmd.sq_b) sq <= sq + ay_w * ay_w;
    if (cmd.rt_prop) begin
      cand   <= cand_c;
      candsq <= cand_w * cand_w;
    end
    if (cmd.rt_upd) begin
      if (sqerr(candsq, sq) < sqerr(rsq, sq)) begin
        r   <= cand;
        rsq <= candsq;
      end
      rstep <= rstep >> 1;
    end
    if (cmd.div_init) begin
      numq  <= cmd.sel ? {ax, 6'b0} : {ay, 6'b0};
      rem   <= '0;
      idx   <= IDX_START;
      tstep <= TSTEP_INIT;
    end
    if (cmd.div_step) begin
      if (!trial[ROOT_W+1]) begin
        rem  <= trial[ROOT_W-1:0];
        numq <= {numq[NUM_W-2:0], 1'b1};
      end else begin
        rem  <= shifted[ROOT_W-1:0];
        numq <= {numq[NUM_W-2:0], 1'b0};
      end
    end
    if (cmd.ts_step) begin
      idx   <= idx_next;
      tstep <= tstep >> 1;
    end
    if (cmd.save) begin
      if (cmd.sel) c_ang <= IDX_W'(ANG_QUART - {1'b0, idx_next});
      else         s_ang <= idx_next;
    end
    if (cmd.finish) angle <= stat.zero ? '0 : folded;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.finish;
    end
  end

endmodule

### tb/tb.sv
// Testbench for byte_angle_arctangent_core: angle requests checked against a
// built-in angle predictor. Depends on bat_pkg and the core RTL.
module tb;
  import bat_pkg::*;

  typedef struct {
    int               x;
    int               y;
    logic [ANG_W-1:0] angle;
  } angle_req_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    start = 1'b0;
  logic signed [VEC_W-1:0] vec_x = '0;
  logic signed [VEC_W-1:0] vec_y = '0;
  logic                    busy;
  logic                    done;
  logic [ANG_W-1:0]        angle;

  angle_req_t expected_angles[$];
  int         fail_count = 0;

  byte_angle_arctangent_core DUT (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .vec_x (vec_x),
    .vec_y (vec_y),
    .busy  (busy),
    .done  (done),
    .angle (angle)
  );

  always #6 clk = ~clk;

  // ---------------------------------------------------------------- predictor

  function automatic int magnitude(int v);
    return v < 0 ? -v : v;
  endfunction

  // -128 is treated as -127
  function automatic int clamp_component(logic signed [VEC_W-1:0] v);
    int c;
    c = int'(v);
    return c < -127 ? -127 : c;
  endfunction

  // quarter sine with the extra entry at index 64
  function automatic int sine_entry(int i);
    if (i >= 64) return 64;
    return int'(QSINE[i & 63]);
  endfunction

  function automatic int nearest_sine_index(int target);
    int idx;
    int stp;
    int here;
    idx = 32;
    for (stp = 16; stp > 0; stp = stp >> 1) begin
      here = magnitude(sine_entry(idx) - target);
      if (sine_entry(idx) > target) begin
        if (here > magnitude(sine_entry(idx - stp) - target)) idx -= stp;
      end else if (here > magnitude(sine_entry(idx + stp) - target)) begin
        idx += stp;
      end
    end
    return idx & 63;
  endfunction

  function automatic logic [ANG_W-1:0] predict_angle(logic signed [VEC_W-1:0] vx,
                                                     logic signed [VEC_W-1:0] vy);
    int x;
    int y;
    int sq;
    int r;
    int cand;
    int stp;
    int s_ang;
    int c_ang;
    int a;
    x = clamp_component(vx);
    y = clamp_component(vy);
    if (x == 0 && y == 0) return '0;
    // binary-search root of x^2 + y^2, keeps the closer candidate
    sq = x * x + y * y;
    r  = 128;
    for (stp = 64; stp > 0; stp = stp / 2) begin
      cand = (r * r > sq) ? r - stp : r + stp;
      if (magnitude(cand * cand - sq) < magnitude(r * r - sq)) r = cand;
    end
    if (r < 1) r = 1;
    s_ang = nearest_sine_index(magnitude(64 * y) / r);
    c_ang = 64 - nearest_sine_index(magnitude(64 * x) / r);
    if (c_ang != s_ang && sine_entry(c_ang) == sine_entry(s_ang)) s_ang = c_ang;
    a = s_ang;
    if (y >= 0) begin
      if (x < 0) a = 128 - a;
    end else if (x <= 0) begin
      a = a + 128;
    end else begin
      a = 256 - a;
    end
    return a[ANG_W-1:0];
  endfunction

  // ---------------------------------------------------------------- checking

  always @(posedge clk) begin : check_angles
    angle_req_t head;
    if (!rst && done) begin
      if (expected_angles.size() == 0) begin
        if (fail_count < 10)
          $display("unexpected result: angle=%0d with no request outstanding", angle);
        fail_count++;
      end else begin
        head = expected_angles.pop_front();
        if (angle !== head.angle) begin
          if (fail_count < 10)
            $display("angle mismatch for x=%0d y=%0d: expected %0d, got %0d",
                     head.x, head.y, head.angle, angle);
          fail_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------- driving

  task automatic apply_reset();
    rst <= 1'b1;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
  endtask

  // Present one request and hold it until the core takes it.
  task automatic send_vector(logic signed [VEC_W-1:0] vx, logic signed [VEC_W-1:0] vy);
    angle_req_t req;
    start <= 1'b1;
    vec_x <= vx;
    vec_y <= vy;
    do @(posedge clk); while (busy);
    req.x     = clamp_component(vx);
    req.y     = clamp_component(vy);
    req.angle = predict_angle(vx, vy);
    expected_angles.push_back(req);
  endtask

  task automatic hold_off(int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic wait_for_angles();
    start <= 1'b0;
    @(posedge clk);
    while (expected_angles.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_directed_vectors();
    int pairs[25][2];
    int i;
    pairs = '{
      '{0, 0},      '{127, 0},    '{0, 127},    '{-127, 0},   '{0, -127},
      '{-128, -128}, '{-128, 0},  '{0, -128},   '{127, 127},  '{-127, 127},
      '{-127, -127}, '{127, -127}, '{1, 0},     '{0, 1},      '{-1, 0},
      '{0, -1},     '{1, 1},      '{-1, -1},    '{127, -128}, '{-128, 127},
      '{1, -127},   '{5, -3},     '{-1, 1},     '{127, 1},    '{-3, -100}
    };
    for (i = 0; i < 25; i++) begin
      send_vector(VEC_W'(pairs[i][0]), VEC_W'(pairs[i][1]));
      if (i % 5 == 4) wait_for_angles();
    end
    wait_for_angles();
  endtask

  task automatic test_random_vectors(int count, int gap_pct);
    int i;
    int kind;
    logic signed [VEC_W-1:0] vx;
    logic signed [VEC_W-1:0] vy;
    for (i = 0; i < count; i++) begin
      kind = $urandom_range(0, 99);
      if (kind < 70) begin
        vx = VEC_W'($urandom_range(0, 255));
        vy = VEC_W'($urandom_range(0, 255));
      end else if (kind < 90) begin
        // short vectors stress the root and division rounding
        vx = VEC_W'($urandom_range(0, 16) - 8);
        vy = VEC_W'($urandom_range(0, 16) - 8);
      end else begin
        // axes sit on quadrant boundaries, diagonals halfway between them
        vx = VEC_W'($urandom_range(0, 255));
        case ($urandom_range(0, 3))
          0: vy = '0;
          1: begin vy = vx; vx = '0; end
          2: vy = vx;
          default: vy = -vx;
        endcase
      end
      send_vector(vx, vy);
      if ($urandom_range(0, 39) == 0) wait_for_angles();
      else if ($urandom_range(0, 99) < gap_pct) hold_off($urandom_range(1, 70));
    end
    wait_for_angles();
  endtask

  task automatic finish_run();
    wait_for_angles();
    repeat (60) @(posedge clk);
    if (fail_count == 0 && expected_angles.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  endtask

  initial begin
    apply_reset();
    test_directed_vectors();
    test_random_vectors(285, 30);
    test_random_vectors(285, 80);
    test_random_vectors(280, 0);
    finish_run();
  end

  initial begin
    #20_000_000;
    $display("status: fail");
    $finish;
  end

endmodule

### sim.f
src/bat_pkg.sv
src/bat_ctrl.sv
src/bat_dp.sv
src/byte_angle_arctangent_core.sv
tb/tb.sv
